@@ src/nsbe_pkg.sv @@
`default_nettype none

package nsbe_pkg;

   localparam int unsigned NIBBLES   = 8;
   localparam int unsigned NUM_KEYS  = 8;
   localparam int unsigned KEY_WIDTH = 32;
   localparam int unsigned BLK_WIDTH = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam int unsigned KEY_SEL_WIDTH   = 3;

   typedef logic [BLK_WIDTH-1:0] block_type;
   typedef logic [3:0]           nibble_type;

   // reduction polynomial x^4+x^3+1, low bits after the shift-out
   localparam nibble_type GF_REDUCE = 4'h9;

   localparam nibble_type SBOX [16] = '{
      4'd3, 4'd2, 4'd15, 4'd11, 4'd5, 4'd12, 4'd7, 4'd13,
      4'd0, 4'd14, 4'd8, 4'd9, 4'd1, 4'd10, 4'd4, 4'd6
   };

   // output nibble n takes input nibble PERM_SRC[n]
   localparam logic [2:0] PERM_SRC [8] = '{
      3'd1, 3'd3, 3'd5, 3'd7, 3'd0, 3'd2, 3'd4, 3'd6
   };

   function automatic nibble_type get_nib(input block_type b, input int unsigned n);
      get_nib = b[BLK_WIDTH-1-4*n -: 4];
   endfunction

   function automatic nibble_type gf_mul2(input nibble_type x);
      gf_mul2 = {x[2:0], 1'b0} ^ (x[3] ? GF_REDUCE : 4'h0);
   endfunction

   function automatic nibble_type gf_mul3(input nibble_type x);
      gf_mul3 = gf_mul2(x) ^ x;
   endfunction

   function automatic block_type sub_nibbles(input block_type b);
      block_type r;
      r = '0;
      for (int unsigned n = 0; n < NIBBLES; n++) begin
         r[BLK_WIDTH-1-4*n -: 4] = SBOX[get_nib(b, n)];
      end
      sub_nibbles = r;
   endfunction

   function automatic block_type mix_columns(input block_type b);
      block_type  r;
      nibble_type a0, a1, a2, a3;
      r = '0;
      for (int unsigned c = 0; c < 2; c++) begin
         a0 = get_nib(b, c);
         a1 = get_nib(b, 2 + c);
         a2 = get_nib(b, 4 + c);
         a3 = get_nib(b, 6 + c);
         r[BLK_WIDTH-1-4*c       -: 4] = gf_mul2(a0) ^ gf_mul3(a1) ^ a2 ^ a3;
         r[BLK_WIDTH-1-4*(2 + c) -: 4] = a0 ^ gf_mul2(a1) ^ gf_mul3(a2) ^ a3;
         r[BLK_WIDTH-1-4*(4 + c) -: 4] = a0 ^ a1 ^ gf_mul2(a2) ^ gf_mul3(a3);
         r[BLK_WIDTH-1-4*(6 + c) -: 4] = gf_mul3(a0) ^ a1 ^ a2 ^ gf_mul2(a3);
      end
      mix_columns = r;
   endfunction

   function automatic block_type permute(input block_type b);
      block_type r;
      r = '0;
      for (int unsigned n = 0; n < NIBBLES; n++) begin
         r[BLK_WIDTH-1-4*n -: 4] = get_nib(b, int'(PERM_SRC[n]));
      end
      permute = r;
   endfunction

endpackage

`default_nettype wire

@@ src/nsbe_round.sv @@
`default_nettype none

// one cipher round: s-box layer, optional mixing, nibble permutation, key add
module nsbe_round (
   input  wire nsbe_pkg::block_type blk_i,
   input  wire nsbe_pkg::block_type key_i,
   input  wire                      mix_en_i,
   output nsbe_pkg::block_type      blk_o
);

   nsbe_pkg::block_type sub_blk;
   nsbe_pkg::block_type mix_blk;

   always_comb begin
      sub_blk = nsbe_pkg::sub_nibbles(blk_i);
      mix_blk = mix_en_i ? nsbe_pkg::mix_columns(sub_blk) : sub_blk;
      blk_o   = nsbe_pkg::permute(mix_blk) ^ key_i;
   end

endmodule

`default_nettype wire

@@ src/nibble_spn_block_encrypt.sv @@
`default_nettype none

// a plaintext transfer is captured in the input register, then passes through the rounds into the result register
// throughput: one block per cycle while results are taken; all rounds sit in one combinational pass
//   between the input register and the result register
// reset: synchronous, active high; clears both valid flags and all round keys
module nibble_spn_block_encrypt #(
   parameter int unsigned ROUNDS = 7
) (
   input  wire         clock,
   input  wire         reset,

   // configuration write channel
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [nsbe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [nsbe_pkg::KEY_WIDTH-1:0]       csr_wdata,

   // plaintext channel
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_plaintext,

   // ciphertext channel
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_ciphertext
);

   // round key store; the user must write it only while idle, the block does not enforce this
   nsbe_pkg::block_type key_ff [nsbe_pkg::NUM_KEYS];

   // input register
   logic                s1_valid_ff, s1_valid_in;
   nsbe_pkg::block_type s1_block_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   nsbe_pkg::block_type rsp_block_ff;

   logic s2_free;
   logic s1_move;
   logic req_xfer;

   // round chain, one tap per round boundary
   nsbe_pkg::block_type stage_blk [ROUNDS+1];

   // ---------------------------------------------------------------
   // configuration: always ready, writes beyond the key list dropped
   // ---------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int unsigned k = 0; k < nsbe_pkg::NUM_KEYS; k++) begin
            key_ff[k] <= '0;
         end
      end else if (csr_valid && csr_ready &&
                   (csr_index < nsbe_pkg::CSR_INDEX_WIDTH'(nsbe_pkg::NUM_KEYS))) begin
         key_ff[csr_index[nsbe_pkg::KEY_SEL_WIDTH-1:0]] <= csr_wdata;
      end
   end

   // ---------------------------------------------------------------
   // flow control: result register frees when empty or being taken,
   // input register moves on whenever the result register is free
   // ---------------------------------------------------------------
   assign s2_free   = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = req_xfer || (s1_valid_ff && !s2_free);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_block_ff <= req_plaintext;
      end
      if (s1_move) begin
         rsp_block_ff <= stage_blk[ROUNDS];
      end
   end

   // ---------------------------------------------------------------
   // datapath: whitening, then the round chain; the last round skips mixing
   // ---------------------------------------------------------------
   assign stage_blk[0] = s1_block_ff ^ key_ff[0];

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      nsbe_round u_round (
         .blk_i    (stage_blk[r]),
         .key_i    (key_ff[r + 1]),
         .mix_en_i (1'(r != ROUNDS - 1)),
         .blk_o    (stage_blk[r + 1])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ciphertext = rsp_block_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   // input side only stalls when both registers are full and the result is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a full pipeline");

   // a block leaving the input register always lands in the result register
   a_advance: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("block lost between input and result register");

   // an accepted plaintext is held in the input register next cycle
   a_capture: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("accepted plaintext not captured");

endmodule

`default_nettype wire

@@ bench/nsbe_checker.sv @@
`default_nettype none

module nsbe_checker
   import nsbe_pkg::*;
#(
   parameter int unsigned ROUNDS = 7
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_valid,
   input  wire                        csr_ready,
   input  wire  [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [KEY_WIDTH-1:0]       csr_wdata,
   input  wire                        req_valid,
   input  wire                        req_ready,
   input  wire  [31:0]                req_plaintext,
   input  wire                        rsp_valid,
   input  wire                        rsp_ready,
   input  wire  [31:0]                rsp_ciphertext,
   output int unsigned                mismatch_count,
   output int unsigned                ciphertexts_pending,
   output int unsigned                blocks_checked
);

   localparam int unsigned REPORT_LIMIT = 10;
   // x^4+x^3+1 folded back after the shift-out of bit 3
   localparam logic [3:0]  FIELD_POLY   = 4'h9;

   logic [31:0] round_keys [NUM_KEYS];
   logic [31:0] expected_ct [$];
   int unsigned errors  = 0;
   int unsigned checked = 0;

   function automatic logic [3:0] substitute(input logic [3:0] x);
      case (x)
         4'h0: return 4'd3;
         4'h1: return 4'd2;
         4'h2: return 4'd15;
         4'h3: return 4'd11;
         4'h4: return 4'd5;
         4'h5: return 4'd12;
         4'h6: return 4'd7;
         4'h7: return 4'd13;
         4'h8: return 4'd0;
         4'h9: return 4'd14;
         4'ha: return 4'd8;
         4'hb: return 4'd9;
         4'hc: return 4'd1;
         4'hd: return 4'd10;
         4'he: return 4'd4;
         default: return 4'd6;
      endcase
   endfunction

   function automatic logic [3:0] times_two(input logic [3:0] x);
      return {x[2:0], 1'b0} ^ (x[3] ? FIELD_POLY : 4'h0);
   endfunction

   function automatic logic [31:0] encrypt_block(input logic [31:0] plaintext);
      logic [3:0]  st [8];
      logic [3:0]  a0, a1, a2, a3;
      logic [31:0] blk;
      int          r, n, c;
      blk = plaintext ^ round_keys[0];
      for (r = 0; r < ROUNDS; r++) begin
         for (n = 0; n < 8; n++)
            st[n] = substitute(blk[31-4*n -: 4]);
         // last round has no column mixing
         if (r != ROUNDS - 1) begin
            for (c = 0; c < 2; c++) begin
               a0 = st[c];
               a1 = st[2+c];
               a2 = st[4+c];
               a3 = st[6+c];
               st[c]   = times_two(a0) ^ times_two(a1) ^ a1 ^ a2 ^ a3;
               st[2+c] = a0 ^ times_two(a1) ^ times_two(a2) ^ a2 ^ a3;
               st[4+c] = a0 ^ a1 ^ times_two(a2) ^ times_two(a3) ^ a3;
               st[6+c] = times_two(a0) ^ a0 ^ a1 ^ a2 ^ times_two(a3);
            end
         end
         // odd nibbles to the top half, even ones to the bottom
         for (n = 0; n < 8; n++)
            blk[31-4*n -: 4] = (n < 4) ? st[2*n+1] : st[2*n-8];
         blk = blk ^ round_keys[(r + 1) % NUM_KEYS];
      end
      return blk;
   endfunction

   always @(posedge clock) begin : track
      logic [31:0] want;
      int          k;
      if (reset) begin
         for (k = 0; k < NUM_KEYS; k++)
            round_keys[k] = '0;
         expected_ct.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_ct.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("ciphertext %h with no plaintext outstanding", rsp_ciphertext);
            end else begin
               want = expected_ct.pop_front();
               checked++;
               if (rsp_ciphertext !== want) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("ciphertext mismatch: expected %h, got %h", want,
                              rsp_ciphertext);
               end
            end
         end
         if (req_valid && req_ready)
            expected_ct.push_back(encrypt_block(req_plaintext));
         // indexes past the key file are dropped
         if (csr_valid && csr_ready && csr_index < NUM_KEYS)
            round_keys[csr_index[KEY_SEL_WIDTH-1:0]] = csr_wdata;
      end
      mismatch_count      <= errors;
      ciphertexts_pending <= expected_ct.size();
      blocks_checked      <= checked;
   end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none

module tb;
   import nsbe_pkg::*;

   localparam int unsigned ROUNDS           = 7;
   // pipeline is two deep, a few spare cycles cover anything still in flight
   localparam int unsigned SETTLE_CYCLES    = 4;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned WATCHDOG_LIMIT   = 2000;
   localparam int unsigned DIRECTED_COUNT   = 16;
   localparam int unsigned CSR_INDEX_TOP    = (1 << CSR_INDEX_WIDTH) - 1;

   typedef enum int {
      KEYS_ZERO,
      KEYS_ONES,
      KEYS_ALTERNATING,
      KEYS_RANDOM,
      KEYS_SPARSE
   } key_style_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [KEY_WIDTH-1:0]       csr_wdata;
   logic                       req_valid;
   logic                       req_ready;
   logic [31:0]                req_plaintext;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [31:0]                rsp_ciphertext;

   int unsigned mismatch_count;
   int unsigned ciphertexts_pending;
   int unsigned blocks_checked;

   int unsigned blocks_sent       = 0;
   int unsigned key_sets_loaded   = 0;
   int unsigned long_holds_done   = 0;
   int unsigned quiet_cycles      = 0;
   // raised by the sender, taken up and cleared by the receiver
   bit          long_hold_pending = 1'b0;

   nibble_spn_block_encrypt #(.ROUNDS(ROUNDS)) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_plaintext  (req_plaintext),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ciphertext (rsp_ciphertext)
   );

   nsbe_checker #(.ROUNDS(ROUNDS)) u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_plaintext       (req_plaintext),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_ciphertext      (rsp_ciphertext),
      .mismatch_count      (mismatch_count),
      .ciphertexts_pending (ciphertexts_pending),
      .blocks_checked      (blocks_checked)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                   (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: segments of steady, patchy, sparse or mostly-high ready, and on request
   // one long hold-off so the pipeline fills and backs up into the sender
   initial begin : receiver
      int unsigned seg_len;
      int unsigned mode;
      rsp_ready <= 1'b0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_holds_done++;
         end else begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(1, 30);
            repeat (seg_len) begin
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // corner plaintexts: extremes, every nibble value somewhere in the block,
   // single bits at either end and alternating patterns
   function automatic logic [31:0] directed_block(input int unsigned i);
      case (i)
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h0123_4567;
         3:       return 32'h89ab_cdef;
         4:       return 32'hfedc_ba98;
         5:       return 32'h7654_3210;
         6:       return 32'h8000_0000;
         7:       return 32'h0000_0001;
         8:       return 32'haaaa_aaaa;
         9:       return 32'h5555_5555;
         10:      return 32'hf0f0_f0f0;
         11:      return 32'h0f0f_0f0f;
         12:      return 32'h1111_1111;
         13:      return 32'heeee_eeee;
         14:      return 32'h0000_ffff;
         default: return 32'hffff_0000;
      endcase
   endfunction

   // mostly uniform, with some sparse and extreme blocks mixed in
   function automatic logic [31:0] random_plaintext();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
         1:       v = 32'($urandom_range(0, 15)) << (4 * $urandom_range(0, 7));
         2:       v = 32'h1 << $urandom_range(0, 31);
         3:       v = ~(32'h1 << $urandom_range(0, 31));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_block(input logic [31:0] pt);
      req_valid     <= 1'b1;
      req_plaintext <= pt;
      do @(posedge clock); while (!req_ready);
      blocks_sent++;
   endtask

   // checker outputs are registered, so wait for the next edge before trusting them
   task automatic wait_for_drain();
      @(posedge clock);
      while (ciphertexts_pending != 0)
         @(posedge clock);
   endtask

   // key writes only happen with the pipeline empty; csr_valid stays high
   // across the whole sequence and drops once after the last transfer
   task automatic load_round_keys(input key_style_type style);
      int k;
      for (k = 0; k < NUM_KEYS; k++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_INDEX_WIDTH'(k);
         case (style)
            KEYS_ZERO:        csr_wdata <= 32'h0000_0000;
            KEYS_ONES:        csr_wdata <= 32'hffff_ffff;
            KEYS_ALTERNATING: csr_wdata <= k[0] ? 32'haaaa_aaaa : 32'h5555_5555;
            KEYS_SPARSE:      csr_wdata <= 32'h1 << $urandom_range(0, 31);
            default:          csr_wdata <= $urandom;
         endcase
         do @(posedge clock); while (!csr_ready);
      end
      // stray write past the key file, must leave every key alone
      csr_index <= CSR_INDEX_WIDTH'($urandom_range(NUM_KEYS, CSR_INDEX_TOP));
      csr_wdata <= $urandom;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      key_sets_loaded++;
   endtask

   // one key set, then random blocks in bursts with random gaps between them
   task automatic run_phase(input key_style_type style, input int unsigned n_items,
                            input bit with_long_hold);
      int unsigned left;
      int unsigned burst;
      int unsigned gap;
      load_round_keys(style);
      left = n_items;
      while (left > 0) begin
         burst = $urandom_range(1, 16);
         if (burst > left)
            burst = left;
         repeat (burst) begin
            send_block(random_plaintext());
            left--;
            if (with_long_hold && left == n_items - 20)
               long_hold_pending = 1'b1;
         end
         // a zero gap merges this burst with the next one
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0 || left == 0) begin
            req_valid <= 1'b0;
            if ($urandom_range(0, 24) == 0)
               wait_for_drain();
            repeat (gap) @(posedge clock);
         end
      end
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned i;
      reset         <= 1'b1;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      req_valid     <= 1'b0;
      req_plaintext <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner blocks back to back under the all-zero keys left by reset
      for (i = 0; i < DIRECTED_COUNT; i++)
         send_block(directed_block(i));
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      run_phase(KEYS_ONES,        70,  1'b0);
      run_phase(KEYS_RANDOM,      90,  1'b0);
      run_phase(KEYS_ALTERNATING, 60,  1'b0);
      run_phase(KEYS_RANDOM,      110, 1'b1);
      run_phase(KEYS_ZERO,        60,  1'b0);
      run_phase(KEYS_SPARSE,      60,  1'b0);

      $display("%0d blocks sent under %0d key sets, %0d ciphertexts compared",
               blocks_sent, key_sets_loaded, blocks_checked);
      $display("long receiver hold-offs: %0d of %0d cycles each",
               long_holds_done, LONG_HOLD_CYCLES);
      if (mismatch_count == 0 && ciphertexts_pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
src/nsbe_pkg.sv
src/nsbe_round.sv
src/nibble_spn_block_encrypt.sv
bench/nsbe_checker.sv
bench/tb.sv
